// File: hdl/grp_pkg.sv
// Package for the guillotine rectangle packer: constants, types and codes.
package grp_pkg;
  localparam int FREE_DEPTH = 64;
  localparam int COORD_BITS = 15;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 15;

  localparam logic [CFG_IDX_BITS-1:0] REG_PAGE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_PIXELS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAGE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROTATE_ENABLE = 3'd4;

  typedef struct packed {
    logic start_job;
    logic start_try;
    logic scan;
    logic place;
    logic carve_step;
    logic push_right;
    logic push_bottom;
    logic new_page;
    logic finish;
  } grp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic fits_page;
    logic fits_new;
    logic carve_done;
    logic page_ok;
    logic rot_ok;
  } grp_status_t;
endpackage

// File: hdl/grp_if.sv
// Valid/ready channel interface carrying a payload of generic type.
interface grp_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hdl/guillotine_rectangle_packer_core.sv
// Top level of the guillotine rectangle packer.
// The block packs rectangles one request at a time. A request on the "in"
// channel carries job_start, rect_width and rect_height; the result on the
// "out" channel carries placed, page_number, pos_x, pos_y, was_rotated and
// store_full. The configuration port writes page size, padding, page limit
// and the rotation enable; the user must write them only while the block is
// idle; the block itself does not enforce this. Each orientation tried scans
// the free list, removing the chosen entry shifts the entries behind it down,
// and then come placing, the two appends and the output. The worst case
// scans both orientations and removes entry 0. The free-list memory is read
// one entry a cycle.
// A new request is taken only once the result has been taken.
// At reset the registers take their reset values, the page counter is zero
// and the free list holds one full-page entry.
// When the receiver stalls, the result is held and no request is accepted.
module guillotine_rectangle_packer_core #(
  parameter int FREE_DEPTH = grp_pkg::FREE_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic cfg_write,
  input logic [grp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [grp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input logic in_valid,
  output logic in_ready,
  input logic in_job_start,
  input logic [14:0] in_rect_width,
  input logic [14:0] in_rect_height,
  output logic out_valid,
  input logic out_ready,
  output logic placed,
  output logic [7:0] page_number,
  output logic [14:0] pos_x,
  output logic [14:0] pos_y,
  output logic was_rotated,
  output logic store_full
);
  grp_pkg::grp_cmd_t cmd;
  grp_pkg::grp_status_t status;
  logic rot;

  grp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd, .rot
  );

  grp_datapath #(.FREE_DEPTH(FREE_DEPTH)) u_dp (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_job_start,
    .in_rect_width, .in_rect_height, .cmd, .rot, .status, .placed,
    .page_number, .pos_x, .pos_y, .was_rotated, .store_full
  );
endmodule

// File: hdl/grp_ctrl.sv
// Controller state machine sequencing the search, removal, appends and new-page step.
module grp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  grp_pkg::grp_status_t status,
  output grp_pkg::grp_cmd_t cmd,
  output logic rot
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_TRY = 9'b000000010, S_SCAN = 9'b000000100,
    S_PLACE = 9'b000001000, S_CARVE = 9'b000010000, S_RIGHT = 9'b000100000,
    S_BOTTOM = 9'b001000000, S_NEWPG = 9'b010000000, S_OUT = 9'b100000000
  } state_t;
  state_t state, state_next;
  logic rot_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    rot_next = rot;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start_job = 1'b1;
          rot_next = 1'b0;
          state_next = S_TRY;
        end
      end
      S_TRY: begin
        cmd.start_try = 1'b1;
        state_next = status.fits_page ? S_SCAN : (rot == 1'b0 && status.rot_ok ?
                     S_TRY : S_NEWPG);
        if (!status.fits_page && rot == 1'b0 && status.rot_ok) rot_next = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          if (status.found) begin
            state_next = S_PLACE;
          end else if (rot == 1'b0 && status.rot_ok) begin
            rot_next = 1'b1;
            state_next = S_TRY;
          end else begin
            state_next = S_NEWPG;
          end
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_next = S_CARVE;
      end
      S_CARVE: begin
        cmd.carve_step = 1'b1;
        if (status.carve_done) state_next = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.push_right = 1'b1;
        state_next = S_BOTTOM;
      end
      S_BOTTOM: begin
        cmd.push_bottom = 1'b1;
        state_next = S_OUT;
      end
      S_NEWPG: begin
        cmd.new_page = 1'b1;
        if (status.page_ok && status.fits_new) begin
          rot_next = 1'b0;
          state_next = S_PLACE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rot <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rot <= rot_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// File: hdl/grp_datapath.sv
// Datapath: configuration, free-rectangle memory, area scan and splits.
module grp_datapath #(
  parameter int FREE_DEPTH = grp_pkg::FREE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [grp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [grp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic in_job_start,
  input  logic [14:0] in_rect_width,
  input  logic [14:0] in_rect_height,
  input  grp_pkg::grp_cmd_t cmd,
  input  logic rot,
  output grp_pkg::grp_status_t status,
  output logic placed,
  output logic [7:0] page_number,
  output logic [14:0] pos_x,
  output logic [14:0] pos_y,
  output logic was_rotated,
  output logic store_full
);
  localparam int COORD_BITS = grp_pkg::COORD_BITS;
  localparam int IW = $clog2(FREE_DEPTH);
  localparam int CW = IW + 1;
  localparam int EW = 4 * COORD_BITS;
  localparam int AW = 2 * 17;
  localparam logic [CW-1:0] DEPTH_C = CW'(FREE_DEPTH);

  logic [14:0] page_width, page_height;
  logic [7:0] pad_pixels;
  logic [8:0] page_limit;
  logic rotate_enable;
  logic [EW-1:0] mem [FREE_DEPTH];
  logic [CW-1:0] free_count;
  logic [7:0] current_page;
  logic [16:0] w, h;
  logic [16:0] pw, ph;
  logic [16:0] try_pw, try_ph;
  logic [CW-1:0] ptr, best_idx, mv;
  logic [AW-1:0] best, area_p;
  logic found, scanning, rd_valid, lost;
  logic [EW-1:0] rd, fr;
  logic [CW-1:0] rd_idx;
  logic [COORD_BITS-1:0] rx, ry, rw, rh, fx, fy, fw, fh;
  logic [16:0] pwl, phl;
  logic [AW-1:0] area_f, waste;
  logic fit;
  logic [COORD_BITS-1:0] cpw, cph;

  assign cpw = COORD_BITS'(page_width);
  assign cph = COORD_BITS'(page_height);
  assign {rx, ry, rw, rh} = rd;
  assign {fx, fy, fw, fh} = fr;
  assign fit = (17'(rw) >= pw) && (17'(rh) >= ph);
  assign area_f = AW'(rw) * AW'(rh);
  assign waste = area_f - area_p;
  assign try_pw = rot ? h : w;
  assign try_ph = rot ? w : h;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_width <= 15'd2048;
      page_height <= 15'd2048;
      pad_pixels <= 8'd0;
      page_limit <= 9'd16;
      rotate_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        grp_pkg::REG_PAGE_WIDTH: page_width <= cfg_data;
        grp_pkg::REG_PAGE_HEIGHT: page_height <= cfg_data;
        grp_pkg::REG_PAD_PIXELS: pad_pixels <= cfg_data[7:0];
        grp_pkg::REG_PAGE_LIMIT: page_limit <= cfg_data[8:0];
        grp_pkg::REG_ROTATE_ENABLE: rotate_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign status.scan_done = scanning == 1'b0 && rd_valid == 1'b0 && cmd.scan;
  assign status.found = found;
  assign status.fits_page = (try_pw <= 17'(page_width)) && (try_ph <= 17'(page_height));
  assign status.fits_new = (w <= 17'(page_width)) && (h <= 17'(page_height));
  assign status.carve_done = (mv + 1'b1 >= free_count);
  assign status.page_ok = (9'(current_page) + 9'd1 < page_limit) && (current_page != 8'hFF);
  assign status.rot_ok = rotate_enable;

  logic mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [IW-1:0] mem_ra;
  logic split_r, split_b;
  assign split_r = fw > COORD_BITS'(pwl);
  assign split_b = fh > COORD_BITS'(phl);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = (cmd.scan && !scanning) ? best_idx[IW-1:0] : ptr[IW-1:0];
    if (rst) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = {COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(2048), COORD_BITS'(2048)};
    end else if (cmd.start_job && in_job_start || cmd.new_page && status.page_ok) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = {COORD_BITS'(0), COORD_BITS'(0), cpw, cph};
    end else if (cmd.carve_step && rd_valid && !status.carve_done) begin
      mem_we = 1'b1;
      mem_wa = IW'(mv);
      mem_wd = rd;
    end else if (cmd.push_right && split_r && free_count < DEPTH_C) begin
      mem_we = 1'b1;
      mem_wa = free_count[IW-1:0];
      mem_wd = {COORD_BITS'(17'(fx) + pwl), fy, COORD_BITS'(17'(fw) - pwl), fh};
    end else if (cmd.push_bottom && split_b && free_count < DEPTH_C) begin
      mem_we = 1'b1;
      mem_wa = free_count[IW-1:0];
      mem_wd = {fx, COORD_BITS'(17'(fy) + phl), COORD_BITS'(pwl),
                COORD_BITS'(17'(fh) - phl)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= CW'(1);
      current_page <= 8'd0;
      scanning <= 1'b0;
      rd_valid <= 1'b0;
      found <= 1'b0;
      ptr <= '0;
      mv <= '0;
      placed <= 1'b0;
      lost <= 1'b0;
    end else begin
      if (cmd.start_job) begin
        w <= 17'(in_rect_width) + 17'(pad_pixels);
        h <= 17'(in_rect_height) + 17'(pad_pixels);
        placed <= 1'b0;
        lost <= 1'b0;
        if (in_job_start) begin
          current_page <= 8'd0;
          free_count <= CW'(1);
        end
      end
      if (cmd.start_try) begin
        pw <= try_pw;
        ph <= try_ph;
        area_p <= AW'(try_pw) * AW'(try_ph);
        ptr <= '0;
        scanning <= 1'b1;
        rd_valid <= 1'b0;
        found <= 1'b0;
        best <= '1;
      end
      if (cmd.scan) begin
        rd_valid <= scanning && ptr < free_count;
        rd_idx <= ptr;
        if (scanning) begin
          if (ptr + 1'b1 >= free_count || ptr >= free_count) scanning <= 1'b0;
          ptr <= ptr + 1'b1;
        end
        if (rd_valid && fit && waste < best) begin
          best <= waste;
          best_idx <= rd_idx;
          found <= 1'b1;
        end
      end
      if (cmd.new_page && status.page_ok) begin
        current_page <= current_page + 8'd1;
        free_count <= CW'(1);
        fr <= {COORD_BITS'(0), COORD_BITS'(0), cpw, cph};
        best_idx <= '0;
        pwl <= w;
        phl <= h;
        was_rotated <= 1'b0;
      end
      if (cmd.place) begin
        if (found) begin
          fr <= rd;
          pwl <= pw;
          phl <= ph;
          was_rotated <= rot;
        end
        placed <= 1'b1;
        mv <= best_idx;
        ptr <= best_idx + 1'b1;
        rd_valid <= 1'b0;
        page_number <= current_page;
        pos_x <= found ? rx : '0;
        pos_y <= found ? ry : '0;
      end
      if (cmd.carve_step) begin
        if (status.carve_done) begin
          free_count <= free_count - 1'b1;
          rd_valid <= 1'b0;
        end else if (!rd_valid) begin
          rd_valid <= 1'b1;
          ptr <= ptr + 1'b1;
        end else begin
          mv <= mv + 1'b1;
          ptr <= ptr + 1'b1;
        end
      end
      if (cmd.push_right && split_r) begin
        if (free_count < DEPTH_C) free_count <= free_count + 1'b1;
        else lost <= 1'b1;
      end
      if (cmd.push_bottom && split_b) begin
        if (free_count < DEPTH_C) free_count <= free_count + 1'b1;
        else lost <= 1'b1;
      end
      if (cmd.finish) store_full <= lost;
      if (cmd.finish && !placed) begin
        page_number <= 8'd0;
        pos_x <= '0;
        pos_y <= '0;
        was_rotated <= 1'b0;
      end
    end
  end
endmodule

// File: hdl/grp_checker.sv
// Port-level checker for the packer, bound to the top level.
module grp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic placed,
  input logic [7:0] page_number,
  input logic [14:0] pos_x
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x))
    else $error("result dropped under stall");
  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed |-> page_number == 8'd0 && pos_x == 15'd0)
    else $error("unplaced result has nonzero position");
  a_accept_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind guillotine_rectangle_packer_core grp_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .placed, .page_number, .pos_x
);

// File: tb/tb_top.sv
// Self-checking testbench for the guillotine rectangle packer core.
`timescale 1ns / 100ps

module tb_top;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic job_start;
    logic [14:0] rect_width;
    logic [14:0] rect_height;
  } rect_req_t;

  typedef struct packed {
    logic placed;
    logic [7:0] page_number;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic was_rotated;
    logic store_full;
  } place_res_t;

  typedef struct {
    logic job_start;
    int unsigned w;
    int unsigned h;
    bit typed;
    place_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [grp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [grp_pkg::CFG_DATA_BITS-1:0] cfg_data;

  grp_if #(.T(rect_req_t)) req_ch (clk);
  grp_if #(.T(place_res_t)) res_ch (clk);

  guillotine_rectangle_packer_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(req_ch.valid),
    .in_ready(req_ch.ready),
    .in_job_start(req_ch.data.job_start),
    .in_rect_width(req_ch.data.rect_width),
    .in_rect_height(req_ch.data.rect_height),
    .out_valid(res_ch.valid),
    .out_ready(res_ch.ready),
    .placed(res_ch.data.placed),
    .page_number(res_ch.data.page_number),
    .pos_x(res_ch.data.pos_x),
    .pos_y(res_ch.data.pos_y),
    .was_rotated(res_ch.data.was_rotated),
    .store_full(res_ch.data.store_full)
  );

  always #6 clk = ~clk;

  // Predictor state.
  int unsigned pg_w, pg_h, pad, pg_limit, rot_en;
  logic [14:0] fx[grp_pkg::FREE_DEPTH], fy[grp_pkg::FREE_DEPTH];
  logic [14:0] fw[grp_pkg::FREE_DEPTH], fh[grp_pkg::FREE_DEPTH];
  int unsigned free_cnt, cur_page;

  place_res_t placement_q[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  int n_placed = 0, n_unplaced = 0, n_rotated = 0, n_full = 0;

  function automatic void open_page();
    for (int i = 0; i < grp_pkg::FREE_DEPTH; i++) begin
      fx[i] = '0; fy[i] = '0; fw[i] = '0; fh[i] = '0;
    end
    fw[0] = pg_w[14:0];
    fh[0] = pg_h[14:0];
    free_cnt = 1;
  endfunction

  function automatic bit add_free(int unsigned x, int unsigned y, int unsigned w,
                                  int unsigned h);
    if (free_cnt >= grp_pkg::FREE_DEPTH) return 1'b0;
    fx[free_cnt] = x[14:0];
    fy[free_cnt] = y[14:0];
    fw[free_cnt] = w[14:0];
    fh[free_cnt] = h[14:0];
    free_cnt++;
    return 1'b1;
  endfunction

  function automatic bit split_free(int unsigned idx, int unsigned pw, int unsigned ph);
    int unsigned x, y, w, h;
    bit lost;
    lost = 1'b0;
    x = fx[idx]; y = fy[idx]; w = fw[idx]; h = fh[idx];
    for (int unsigned i = idx; i + 1 < free_cnt; i++) begin
      fx[i] = fx[i+1]; fy[i] = fy[i+1]; fw[i] = fw[i+1]; fh[i] = fh[i+1];
    end
    free_cnt--;
    if (w > pw && !add_free(x + pw, y, w - pw, h)) lost = 1'b1;
    if (h > ph && !add_free(x, y + ph, pw, h - ph)) lost = 1'b1;
    return lost;
  endfunction

  function automatic place_res_t pack_rect(rect_req_t rq);
    place_res_t r;
    int unsigned w, h, pw, ph, best_idx;
    longint unsigned waste, best;
    bit found, done;
    r = '0;
    done = 1'b0;
    if (rq.job_start) begin
      cur_page = 0;
      open_page();
    end
    w = rq.rect_width + pad;
    h = rq.rect_height + pad;
    for (int rot = 0; rot < (rot_en ? 2 : 1) && !done; rot++) begin
      pw = rot ? h : w;
      ph = rot ? w : h;
      if (pw > pg_w || ph > pg_h) continue;
      found = 1'b0;
      best = '1;
      best_idx = 0;
      for (int unsigned i = 0; i < free_cnt; i++) begin
        if (fw[i] >= pw && fh[i] >= ph) begin
          waste = longint'(fw[i]) * fh[i] - longint'(pw) * ph;
          if (waste < best) begin
            best = waste;
            best_idx = i;
            found = 1'b1;
          end
        end
      end
      if (!found) continue;
      r.placed = 1'b1;
      r.pos_x = fx[best_idx];
      r.pos_y = fy[best_idx];
      r.was_rotated = rot[0];
      r.page_number = cur_page[7:0];
      r.store_full = split_free(best_idx, pw, ph);
      done = 1'b1;
    end
    if (!done && cur_page + 1 < pg_limit && cur_page < 255) begin
      cur_page++;
      open_page();
      if (w <= pg_w && h <= pg_h) begin
        r.placed = 1'b1;
        r.page_number = cur_page[7:0];
        r.store_full = split_free(0, w, h);
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [grp_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[grp_pkg::CFG_DATA_BITS-1:0];
    case (idx)
      grp_pkg::REG_PAGE_WIDTH: pg_w = val & 32'h7FFF;
      grp_pkg::REG_PAGE_HEIGHT: pg_h = val & 32'h7FFF;
      grp_pkg::REG_PAD_PIXELS: pad = val & 32'hFF;
      grp_pkg::REG_PAGE_LIMIT: pg_limit = val & 32'h1FF;
      grp_pkg::REG_ROTATE_ENABLE: rot_en = val & 32'h1;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned p,
                           int unsigned lim, int unsigned r);
    wait_drained();
    write_reg(grp_pkg::REG_PAGE_WIDTH, w);
    write_reg(grp_pkg::REG_PAGE_HEIGHT, h);
    write_reg(grp_pkg::REG_PAD_PIXELS, p);
    write_reg(grp_pkg::REG_PAGE_LIMIT, lim);
    write_reg(grp_pkg::REG_ROTATE_ENABLE, r);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Drives one request; the expected placement is queued at acceptance.
  task automatic send_rect(rect_req_t rq, bit typed, place_res_t typed_res);
    place_res_t exp_res;
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= rq;
    do @(posedge clk); while (!req_ch.ready);
    exp_res = pack_rect(rq);
    placement_q = {placement_q, (typed ? typed_res : exp_res)};
  endtask

  function automatic int unsigned pick_size(int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, (limit / 8 > 0) ? limit / 8 : 1);
    if (r < 85) return $urandom_range(0, (limit > 16384) ? 16384 : limit);
    if (r < 95) return $urandom_range(0, 16384);
    return 16384;
  endfunction

  task automatic random_jobs(int n_items);
    rect_req_t rq;
    int job_len;
    job_len = 0;
    for (int k = 0; k < n_items; k++) begin
      if (job_len == 0) job_len = $urandom_range(1, 90);
      rq.job_start = (job_len == 1 && k != 0) ? 1'b0 : 1'b0;
      rq.job_start = ($urandom_range(0, 99) < 3) || (k == 0);
      rq.rect_width = 15'(pick_size(pg_w));
      rq.rect_height = 15'(pick_size(pg_h));
      job_len--;
      if (job_len == 0) rq.job_start = 1'b1;
      send_rect(rq, 1'b0, '0);
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{1'b1, 2048, 2048, 1'b1, place_res_t'{1'b1, 8'd0, 15'd0, 15'd0, 1'b0, 1'b0}},
    '{1'b0, 16384, 16384, 1'b1, place_res_t'{1'b0, 8'd0, 15'd0, 15'd0, 1'b0, 1'b0}},
    '{1'b0, 0, 0, 1'b0, place_res_t'('0)},
    '{1'b1, 10, 20, 1'b1, place_res_t'{1'b1, 8'd0, 15'd0, 15'd0, 1'b0, 1'b0}},
    '{1'b0, 2048, 10, 1'b0, place_res_t'('0)},
    '{1'b0, 16384, 0, 1'b0, place_res_t'('0)},
    '{1'b0, 0, 16384, 1'b0, place_res_t'('0)},
    '{1'b0, 1, 1, 1'b0, place_res_t'('0)},
    '{1'b0, 16383, 1, 1'b0, place_res_t'('0)},
    '{1'b1, 1, 2048, 1'b0, place_res_t'('0)},
    '{1'b0, 2047, 2047, 1'b0, place_res_t'('0)},
    '{1'b0, 5461, 10922, 1'b0, place_res_t'('0)},
    '{1'b0, 10922, 5461, 1'b0, place_res_t'('0)}
  };

  initial begin
    rect_req_t rq;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= grp_pkg::REG_PAGE_WIDTH;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    pg_w = 2048; pg_h = 2048; pad = 0; pg_limit = 16; rot_en = 1;
    cur_page = 0;
    open_page();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      rq.job_start = dir_rows[i].job_start;
      rq.rect_width = dir_rows[i].w[14:0];
      rq.rect_height = dir_rows[i].h[14:0];
      send_rect(rq, dir_rows[i].typed, dir_rows[i].res);
    end

    configure(2048, 2048, 0, 16, 1);
    random_jobs(150);
    wait_drained();
    random_jobs(150);

    configure(16384, 16384, 0, 256, 1);
    no_idle = 1;
    random_jobs(250);
    no_idle = 0;

    configure(64, 48, 3, 4, 0);
    random_jobs(250);
    configure(1, 1, 0, 1, 1);
    random_jobs(100);
    configure(512, 300, 255, 256, 1);
    random_jobs(200);
    configure(1000, 1000, 1, 2, 0);
    random_jobs(250);
    configure(16384, 1, 255, 256, 1);
    random_jobs(200);

    wait_drained();
    $display("Checked %0d placements (%0d placed, %0d unplaced, %0d rotated, %0d store full).",
             n_placed + n_unplaced, n_placed, n_unplaced, n_rotated, n_full);
    $display("Seven register settings were used, from 1x1 pages to 16384x16384 pages.");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    place_res_t exp_res;
    place_res_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          exp_res = placement_q.pop_front();
          if (got.placed !== exp_res.placed) begin
            $display("%0t: placed expected %0d actual %0d", $time, exp_res.placed, got.placed);
            errors++;
          end
          if (got.page_number !== exp_res.page_number) begin
            $display("%0t: page_number expected %0d actual %0d", $time,
                     exp_res.page_number, got.page_number);
            errors++;
          end
          if (got.pos_x !== exp_res.pos_x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, exp_res.pos_x, got.pos_x);
            errors++;
          end
          if (got.pos_y !== exp_res.pos_y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, exp_res.pos_y, got.pos_y);
            errors++;
          end
          if (got.was_rotated !== exp_res.was_rotated) begin
            $display("%0t: was_rotated expected %0d actual %0d", $time,
                     exp_res.was_rotated, got.was_rotated);
            errors++;
          end
          if (got.store_full !== exp_res.store_full) begin
            $display("%0t: store_full expected %0d actual %0d", $time,
                     exp_res.store_full, got.store_full);
            errors++;
          end
          if (exp_res.placed) n_placed++; else n_unplaced++;
          if (exp_res.was_rotated) n_rotated++;
          if (exp_res.store_full) n_full++;
        end
      end
      res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end
endmodule

// File: files.f
hdl/grp_pkg.sv
hdl/grp_if.sv
hdl/grp_ctrl.sv
hdl/grp_datapath.sv
hdl/guillotine_rectangle_packer_core.sv
hdl/grp_checker.sv
tb/tb_top.sv
